[rtl/assert_macros.svh]
// Assertion macros for the port-level checker in e2p_checker.sv.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define E2P_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked at every edge, reset included
`define E2P_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/e2p_pkg.sv]
// Types, constants and helper functions for the pyramid remap block.
// No dependencies.
package e2p_pkg;

    localparam int ANGLE_BITS    = 18;
    localparam int CORDIC_STAGES = 18;

    localparam int QW       = 20;              // Q3.16 word
    localparam int SW       = 32;              // width fed to saturation
    localparam int BW       = QW + 3;          // side-triangle scratch width
    localparam int CW       = 23;              // CORDIC x/y width
    localparam int ZW       = ANGLE_BITS + 2;  // CORDIC angle width
    localparam int PW       = ZW + 20;         // final scaling product width
    localparam int HW       = 12;              // half of the output side
    localparam int DIV_BITS = 29;              // quotient bits per divide
    localparam int NL       = 3;               // divide lanes

    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_D = 2;

    localparam logic signed [QW-1:0] Q_MAX = QW'(524287);
    localparam logic signed [QW-1:0] Q_MIN = QW'(-524288);
    localparam logic signed [BW-1:0] ONE_B = BW'(65536);
    localparam logic signed [QW:0]   ONE_A = (QW + 1)'(65536);
    localparam logic signed [QW-1:0] NEG_HALF_SQRT2 = QW'(-46341);
    localparam logic signed [SW-1:0] HALF_SQRT2_S = SW'(46341);
    localparam logic signed [31:0]   INV_GAIN_Q30 = 32'sd652032874;

    localparam logic [13:0] SRC_MAX = 14'd8192;

    localparam logic signed [ZW-1:0] QTURN = ZW'(64'd1 << (ANGLE_BITS - 2));
    localparam logic signed [ZW:0]   HTURN_T = (ZW + 1)'(64'd1 << (ANGLE_BITS - 1));
    localparam logic signed [ZW:0]   QTURN_T = (ZW + 1)'(64'd1 << (ANGLE_BITS - 2));
    localparam logic signed [PW-1:0] TURN_P = PW'(64'd1 << ANGLE_BITS);
    localparam int ATAN_SH = 32 - ANGLE_BITS;

    localparam logic [31:0] ATAN_TURN32 [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef enum logic [2:0] {
        RGN_SIDE0 = 3'd0,
        RGN_SIDE1 = 3'd1,
        RGN_SIDE2 = 3'd2,
        RGN_SIDE3 = 3'd3,
        RGN_BASE  = 3'd4
    } region_t;

    typedef enum logic [1:0] {
        CFG_OUT_SIZE   = 2'd0,
        CFG_SRC_WIDTH  = 2'd1,
        CFG_SRC_HEIGHT = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic                         vld;
        region_t                      region;
        logic [NL-1:0]                neg;
        logic [NL-1:0][HW-1:0]        rem;
        logic [NL-1:0][DIV_BITS-1:0]  num;
    } div_t;

    typedef struct packed {
        region_t                region;
        logic signed [QW-1:0]   v2;
        logic signed [ZW-1:0]   a1;
    } side_t;

    typedef struct packed {
        logic                   vld;
        logic                   zero;
        logic signed [CW-1:0]   x;
        logic signed [CW-1:0]   y;
        logic signed [ZW-1:0]   z;
        side_t                  side;
    } cordic_t;

    // step angle of stage k, rounded half up from the 32-bit turn table
    function automatic logic signed [ZW-1:0] atan_step(input logic [4:0] k);
        logic [63:0] v;
        v = {32'd0, ATAN_TURN32[k]};
        if (ATAN_SH > 0)
        begin
            v = (v + (64'd1 << (ATAN_SH - 1))) >> ATAN_SH;
        end
        return $signed(v[ZW-1:0]);
    endfunction

    function automatic logic signed [QW-1:0] sat_q(input logic signed [SW-1:0] v);
        logic signed [QW-1:0] r;
        if (v > SW'(Q_MAX))
            r = Q_MAX;
        else if (v < SW'(Q_MIN))
            r = Q_MIN;
        else
            r = v[QW-1:0];
        return r;
    endfunction

    // left half plane: turn by a quarter so the CORDIC steps converge
    function automatic cordic_t prerot(input logic vld,
                                       input logic signed [CW-1:0] x,
                                       input logic signed [CW-1:0] y,
                                       input side_t side);
        cordic_t r;
        r.vld  = vld;
        r.side = side;
        r.zero = (x == '0) && (y == '0);
        r.x    = x;
        r.y    = y;
        r.z    = '0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                r.x = y;
                r.y = -x;
                r.z = QTURN;
            end
            else
            begin
                r.x = -y;
                r.y = x;
                r.z = -QTURN;
            end
        end
        return r;
    endfunction

endpackage

[rtl/e2p_pix_if.sv]
// Input channel: one output-image pixel position per item.
// No dependencies.
interface e2p_pix_if;
    logic        valid;
    logic        ready;
    logic [11:0] out_row;
    logic [11:0] out_col;

    modport source (output valid, output out_row, output out_col, input ready);
    modport sink   (input valid, input out_row, input out_col, output ready);
endinterface

[rtl/e2p_res_if.sv]
// Result channel: source coordinates and region per item.
// No dependencies.
interface e2p_res_if;
    logic        valid;
    logic        ready;
    logic [12:0] src_row;
    logic [12:0] src_col;
    logic [2:0]  region;

    modport source (output valid, output src_row, output src_col, output region,
                    input ready);
    modport sink   (input valid, input src_row, input src_col, input region,
                    output ready);
endinterface

[rtl/e2p_div_cell.sv]
// One restoring-division cell: one quotient bit for each of three lanes.
// Depends on e2p_pkg.
module e2p_div_cell
    import e2p_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic [HW-1:0] half,
    input  div_t          d_in,
    output div_t          d_reg
);

    div_t d_next;

    always_comb
    begin
        logic [HW:0] tt;
        logic        ge;
        d_next = d_in;
        for (int l = 0; l < NL; l++)
        begin
            tt = {d_in.rem[l], d_in.num[l][DIV_BITS-1]};
            ge = (tt >= {1'b0, half});
            d_next.rem[l] = ge ? HW'(tt - {1'b0, half}) : tt[HW-1:0];
            // quotient bits enter at the bottom as dividend bits leave the top
            d_next.num[l] = {d_in.num[l][DIV_BITS-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_reg <= '0;
        else if (en)
            d_reg <= d_next;
    end

endmodule

[rtl/e2p_cordic_cell.sv]
// One CORDIC vectoring cell; the stage index sets shift and step angle.
// Depends on e2p_pkg.
module e2p_cordic_cell
    import e2p_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic [4:0] stage,
    input  cordic_t    c_in,
    output cordic_t    c_reg
);

    cordic_t              c_next;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] at;

    always_comb
    begin
        dx     = c_in.y >>> stage;
        dy     = c_in.x >>> stage;
        at     = atan_step(stage);
        c_next = c_in;
        // zero vector stays at angle 0, magnitude 0
        if (!c_in.zero)
        begin
            if (c_in.y > 0)
            begin
                c_next.x = c_in.x + dx;
                c_next.y = c_in.y - dy;
                c_next.z = c_in.z + at;
            end
            else
            begin
                c_next.x = c_in.x - dx;
                c_next.y = c_in.y + dy;
                c_next.z = c_in.z - at;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_reg <= '0;
        else if (en)
            c_reg <= c_next;
    end

endmodule

[rtl/equirect_to_pyramid_remap_unit.sv]
// Pyramid output pixel to equirectangular source pixel remapper.
// Takes one item per cycle while no result waits on the output.
// Depth is set by the bit-per-cell divider chain and the two CORDIC chains.
// The whole pipeline holds while a result waits on the output.
// Reset clears all valid bits and loads 1024 / 4096 / 2048 into the registers.
module equirect_to_pyramid_remap_unit
    import e2p_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_data,
    e2p_pix_if.sink     pix,
    e2p_res_if.source   res
);

    logic [12:0] out_size_reg;
    logic [13:0] src_width_reg;
    logic [13:0] src_height_reg;

    logic          adv;
    logic [HW-1:0] half;
    logic [13:0]   w_eff;
    logic [13:0]   h_eff;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_size_reg   <= 13'd1024;
            src_width_reg  <= 14'd4096;
            src_height_reg <= 14'd2048;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_OUT_SIZE:   out_size_reg   <= cfg_data[12:0];
                CFG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                CFG_SRC_HEIGHT: src_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        half = (out_size_reg[12:1] == '0) ? HW'(1) : out_size_reg[12:1];
        if (src_width_reg == '0)
            w_eff = 14'd1;
        else if (src_width_reg > SRC_MAX)
            w_eff = SRC_MAX;
        else
            w_eff = src_width_reg;
        if (src_height_reg == '0)
            h_eff = 14'd1;
        else if (src_height_reg > SRC_MAX)
            h_eff = SRC_MAX;
        else
            h_eff = src_height_reg;
    end

    logic out_vld_reg;
    assign adv       = !out_vld_reg || res.ready;
    assign pix.ready = adv;

    // ---------------- classification and dividend set-up
    div_t s0_reg;
    div_t s0_next;

    always_comb
    begin
        logic signed [14:0] py;
        logic signed [14:0] px;
        logic signed [14:0] hs;
        logic signed [14:0] d;
        logic [14:0]        pxm;
        logic [14:0]        pym;
        logic [14:0]        dm;
        region_t            rg;
        hs = $signed({3'b0, half});
        py = $signed({3'b0, pix.out_row}) - hs;
        px = $signed({3'b0, pix.out_col}) - hs;
        if (py > px + hs)
            rg = RGN_SIDE0;
        else if (py < px - hs)
            rg = RGN_SIDE1;
        else if (py > hs - px)
            rg = RGN_SIDE2;
        else if (py < -px - hs)
            rg = RGN_SIDE3;
        else
            rg = RGN_BASE;
        d   = (rg == RGN_SIDE0 || rg == RGN_SIDE1) ? py - px : py + px;
        pxm = (px < 0) ? 15'(-px) : 15'(px);
        pym = (py < 0) ? 15'(-py) : 15'(py);
        dm  = (d < 0) ? 15'(-d) : 15'(d);
        s0_next.vld         = pix.valid;
        s0_next.region      = rg;
        s0_next.neg[LANE_X] = px[14];
        s0_next.neg[LANE_Y] = py[14];
        s0_next.neg[LANE_D] = d[14];
        s0_next.rem         = '0;
        s0_next.num[LANE_X] = {1'b0, pxm[11:0], 16'h0};
        s0_next.num[LANE_Y] = {1'b0, pym[11:0], 16'h0};
        s0_next.num[LANE_D] = {dm[12:0], 16'h0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_reg <= '0;
        else if (adv)
            s0_reg <= s0_next;
    end

    // ---------------- divider chain
    div_t dv [DIV_BITS];

    for (genvar gi = 0; gi < DIV_BITS; gi++)
    begin : g_div
        if (gi == 0)
        begin : g_first
            e2p_div_cell u_cell (
                .clk(clk), .rst_n(rst_n), .en(adv), .half(half),
                .d_in(s0_reg), .d_reg(dv[gi])
            );
        end
        else
        begin : g_next
            e2p_div_cell u_cell (
                .clk(clk), .rst_n(rst_n), .en(adv), .half(half),
                .d_in(dv[gi-1]), .d_reg(dv[gi])
            );
        end
    end

    // ---------------- vector build
    logic                 a_vld_reg;
    region_t              a_region_reg;
    logic signed [QW-1:0] a_ux_reg, a_uy_reg, a_b_reg;
    logic signed [QW-1:0] a_q_next [NL];

    always_comb
    begin
        logic signed [SW-1:0] qs;
        for (int l = 0; l < NL; l++)
        begin
            qs = $signed({3'b0, dv[DIV_BITS-1].num[l]});
            a_q_next[l] = sat_q(dv[DIV_BITS-1].neg[l] ? -qs : qs);
        end
    end

    logic                 b_vld_reg;
    region_t              b_region_reg;
    logic signed [QW-1:0] b_ux_reg, b_uy_reg, b_t_reg, b_s_reg;
    logic signed [QW-1:0] b_t_next, b_s_next;

    always_comb
    begin
        logic signed [BW-1:0] bm;
        logic signed [BW-1:0] e;
        logic signed [BW-1:0] t;
        logic signed [BW-1:0] f;
        bm = (a_b_reg < 0) ? -BW'(a_b_reg) : BW'(a_b_reg);
        e  = ONE_B - bm;
        t  = (e < 0) ? -e : e;
        f  = t - ONE_B;
        b_t_next = t[QW-1:0];
        b_s_next = (f < 0) ? QW'(-f) : f[QW-1:0];
    end

    logic                 c_vld_reg;
    region_t              c_region_reg;
    logic signed [QW:0]   c_ax_reg, c_ay_reg, c_s_reg;
    logic signed [QW-1:0] c_v2_reg;
    logic signed [QW:0]   c_ax_next, c_ay_next, c_s_next;
    logic signed [QW-1:0] c_v2_next;

    always_comb
    begin
        logic signed [QW:0] ux;
        logic signed [QW:0] uy;
        logic signed [QW:0] t;
        ux = (QW + 1)'(b_ux_reg);
        uy = (QW + 1)'(b_uy_reg);
        t  = (QW + 1)'(b_t_reg);
        if (b_region_reg == RGN_BASE)
        begin
            // scale by one keeps the base vector unchanged through the multiply
            c_ax_next = ux;
            c_ay_next = uy;
            c_s_next  = ONE_A;
            c_v2_next = NEG_HALF_SQRT2;
        end
        else
        begin
            c_ax_next = (b_region_reg == RGN_SIDE0 || b_region_reg == RGN_SIDE3)
                        ? ux + t : ux - t;
            c_ay_next = (b_region_reg == RGN_SIDE1 || b_region_reg == RGN_SIDE3)
                        ? uy + t : uy - t;
            c_s_next  = (QW + 1)'(b_s_reg);
            c_v2_next = sat_q((SW'(b_t_reg) <<< 1) - HALF_SQRT2_S);
        end
    end

    logic                 d_vld_reg;
    region_t              d_region_reg;
    logic signed [QW-1:0] d_v0_reg, d_v1_reg, d_v2_reg;
    logic signed [QW-1:0] d_v0_next, d_v1_next;

    always_comb
    begin
        logic signed [2*QW+1:0] p0;
        logic signed [2*QW+1:0] p1;
        p0 = c_ax_reg * c_s_reg;
        p1 = c_ay_reg * c_s_reg;
        p0 = p0 >>> 16;
        p1 = p1 >>> 16;
        d_v0_next = sat_q(p0[SW-1:0]);
        d_v1_next = sat_q(p1[SW-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= dv[DIV_BITS-1].vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_region_reg <= dv[DIV_BITS-1].region;
            a_ux_reg     <= a_q_next[LANE_X];
            a_uy_reg     <= a_q_next[LANE_Y];
            a_b_reg      <= a_q_next[LANE_D];
            b_region_reg <= a_region_reg;
            b_ux_reg     <= a_ux_reg;
            b_uy_reg     <= a_uy_reg;
            b_t_reg      <= b_t_next;
            b_s_reg      <= b_s_next;
            c_region_reg <= b_region_reg;
            c_ax_reg     <= c_ax_next;
            c_ay_reg     <= c_ay_next;
            c_s_reg      <= c_s_next;
            c_v2_reg     <= c_v2_next;
            d_region_reg <= c_region_reg;
            d_v0_reg     <= d_v0_next;
            d_v1_reg     <= d_v1_next;
            d_v2_reg     <= c_v2_reg;
        end
    end

    // ---------------- azimuth CORDIC
    cordic_t c1_in;
    cordic_t c1 [CORDIC_STAGES];
    side_t   c1_side;

    always_comb
    begin
        c1_side.region = d_region_reg;
        c1_side.v2     = d_v2_reg;
        c1_side.a1     = '0;
        c1_in = prerot(d_vld_reg, CW'(d_v0_reg), CW'(d_v1_reg), c1_side);
    end

    for (genvar gi = 0; gi < CORDIC_STAGES; gi++)
    begin : g_cor1
        if (gi == 0)
        begin : g_first
            e2p_cordic_cell u_cell (
                .clk(clk), .rst_n(rst_n), .en(adv), .stage(5'(gi)),
                .c_in(c1_in), .c_reg(c1[gi])
            );
        end
        else
        begin : g_next
            e2p_cordic_cell u_cell (
                .clk(clk), .rst_n(rst_n), .en(adv), .stage(5'(gi)),
                .c_in(c1[gi-1]), .c_reg(c1[gi])
            );
        end
    end

    // ---------------- gain removal
    logic                 m_vld_reg;
    region_t              m_region_reg;
    logic signed [QW-1:0] m_v2_reg;
    logic signed [ZW-1:0] m_a1_reg;
    logic signed [CW-1:0] m_rho_reg;
    logic signed [CW-1:0] m_rho_next;

    always_comb
    begin
        logic signed [CW+31:0] pr;
        pr = c1[CORDIC_STAGES-1].x * INV_GAIN_Q30;
        pr = pr >>> 30;
        m_rho_next = pr[CW-1:0];
    end

    // ---------------- polar CORDIC
    cordic_t c2_in;
    cordic_t c2 [CORDIC_STAGES];
    side_t   c2_side;

    always_comb
    begin
        c2_side.region = m_region_reg;
        c2_side.v2     = m_v2_reg;
        c2_side.a1     = m_a1_reg;
        c2_in = prerot(m_vld_reg, m_rho_reg, CW'(m_v2_reg), c2_side);
    end

    for (genvar gi = 0; gi < CORDIC_STAGES; gi++)
    begin : g_cor2
        if (gi == 0)
        begin : g_first
            e2p_cordic_cell u_cell (
                .clk(clk), .rst_n(rst_n), .en(adv), .stage(5'(gi)),
                .c_in(c2_in), .c_reg(c2[gi])
            );
        end
        else
        begin : g_next
            e2p_cordic_cell u_cell (
                .clk(clk), .rst_n(rst_n), .en(adv), .stage(5'(gi)),
                .c_in(c2[gi-1]), .c_reg(c2[gi])
            );
        end
    end

    // ---------------- angle to source pixel scaling
    logic                 f_vld_reg;
    region_t              f_region_reg;
    logic signed [PW-1:0] f_pc_reg, f_pr_reg;
    logic signed [PW-1:0] f_pc_next, f_pr_next;

    always_comb
    begin
        logic signed [ZW:0]    tt;
        logic signed [ZW:0]    pp;
        logic signed [ZW+15:0] mc;
        logic signed [ZW+15:0] mr;
        tt = (ZW + 1)'(c2[CORDIC_STAGES-1].side.a1) + HTURN_T;
        pp = (ZW + 1)'(c2[CORDIC_STAGES-1].z) + QTURN_T;
        mc = tt * $signed({1'b0, w_eff});
        mr = pp * $signed({1'b0, h_eff});
        f_pc_next = (PW'(mc) <<< 1) - TURN_P;
        f_pr_next = (PW'(mr) <<< 2) - TURN_P;
    end

    logic        out_vld_next;
    logic [12:0] src_row_reg, src_col_reg;
    region_t     region_reg;
    logic [12:0] src_row_next, src_col_next;

    always_comb
    begin
        logic signed [PW-1:0] sc;
        logic signed [PW-1:0] sr;
        logic signed [PW-1:0] ws;
        logic signed [PW-1:0] hs;
        ws = $signed(PW'(w_eff));
        hs = $signed(PW'(h_eff));
        sc = (f_pc_reg >>> (ANGLE_BITS + 1)) + $signed(PW'(w_eff[13:1]));
        sr = f_pr_reg >>> (ANGLE_BITS + 1);
        if (sc > ws)
            sc = sc - ws;
        if (sc < 0)
            src_col_next = '0;
        else if (sc > ws - 1)
            src_col_next = 13'(w_eff - 14'd1);
        else
            src_col_next = sc[12:0];
        if (sr < 0)
            src_row_next = '0;
        else if (sr > hs - 1)
            src_row_next = 13'(h_eff - 14'd1);
        else
            src_row_next = sr[12:0];
        out_vld_next = f_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg   <= 1'b0;
            f_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_vld_reg   <= c1[CORDIC_STAGES-1].vld;
            f_vld_reg   <= c2[CORDIC_STAGES-1].vld;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_region_reg <= c1[CORDIC_STAGES-1].side.region;
            m_v2_reg     <= c1[CORDIC_STAGES-1].side.v2;
            m_a1_reg     <= c1[CORDIC_STAGES-1].z;
            m_rho_reg    <= m_rho_next;
            f_region_reg <= c2[CORDIC_STAGES-1].side.region;
            f_pc_reg     <= f_pc_next;
            f_pr_reg     <= f_pr_next;
            region_reg   <= f_region_reg;
            src_row_reg  <= src_row_next;
            src_col_reg  <= src_col_next;
        end
    end

    assign res.valid   = out_vld_reg;
    assign res.src_row = src_row_reg;
    assign res.src_col = src_col_reg;
    assign res.region  = region_reg;

endmodule

[rtl/e2p_checker.sv]
// Port-level checks for the pyramid remap block, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module e2p_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        pix_valid,
    input logic        pix_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [12:0] res_src_row,
    input logic [12:0] res_src_col,
    input logic [2:0]  res_region
);

    // region code is a side triangle or the base
    `E2P_ASSERT(a_region_code, res_valid |-> (res_region <= 3'd4), "region code out of range")

    // a stalled result holds its payload
    `E2P_ASSERT(a_res_hold, (res_valid && !res_ready) |=> (res_valid && $stable(res_src_row) && $stable(res_src_col) && $stable(res_region)), "stalled item changed")

    // stalled output stops intake
    `E2P_ASSERT(a_backpressure, (res_valid && !res_ready) |-> !pix_ready, "item taken while output stalled")

    // nothing comes out right after reset
    `E2P_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !res_valid, "result valid after reset")

endmodule

bind equirect_to_pyramid_remap_unit e2p_checker u_e2p_checker (
    .clk(clk),
    .rst_n(rst_n),
    .pix_valid(pix.valid),
    .pix_ready(pix.ready),
    .res_valid(res.valid),
    .res_ready(res.ready),
    .res_src_row(res.src_row),
    .res_src_col(res.src_col),
    .res_region(res.region)
);

[tb/sv/e2p_remap_checker.sv]
`timescale 1ns / 100ps
// Checker for the pyramid remap block: watches both channels, predicts
// source coordinates and region, compares in order. Needs e2p_pkg and both channel interfaces.
module e2p_remap_checker
    import e2p_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_data,
    e2p_pix_if          pix,
    e2p_res_if          res,
    output int          fail_count,
    output int          pending,
    output int          matched
);

    typedef struct {
        logic [12:0] src_row;
        logic [12:0] src_col;
        region_t     region;
    } remap_t;

    localparam longint TURN = 64'sd1 << ANGLE_BITS;

    logic [12:0] cur_size;
    logic [13:0] cur_width;
    logic [13:0] cur_height;
    remap_t      coord_q[$];

    function automatic longint shr_floor(longint x, int k);
        return x >>> k;
    endfunction

    function automatic longint sat20(longint x);
        if (x > 524287)
            return 524287;
        if (x < -524288)
            return -524288;
        return x;
    endfunction

    function automatic longint step_angle(int k);
        longint v;
        v = ATAN_TURN32[k & 31];
        if (32 - ANGLE_BITS == 0)
            return v;
        return (v + (64'sd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
    endfunction

    function automatic longint turn_angle(longint x, longint y, output longint mag);
        longint z;
        longint tx;
        longint dx;
        longint dy;
        z = 0;
        if (x == 0 && y == 0)
        begin
            mag = 0;
            return 0;
        end
        if (x < 0)
        begin
            tx = x;
            if (y >= 0)
            begin
                x = y;
                y = -tx;
                z = TURN / 4;
            end
            else
            begin
                x = -y;
                y = tx;
                z = -(TURN / 4);
            end
        end
        for (int k = 0; k < CORDIC_STAGES && k < 32; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (y > 0)
            begin
                x += dx;
                y -= dy;
                z += step_angle(k);
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= step_angle(k);
            end
        end
        mag = x;
        return z;
    endfunction

    function automatic remap_t remap_pixel(logic [11:0] row, logic [11:0] col);
        longint half, w, h, py, px, ux, uy, v0, v1, v2, a1, a2, m, rho, dm;
        longint d, b, t, s, ax, ay, tt, pp, scol, srow;
        region_t rg;
        remap_t r;
        half = cur_size >> 1;
        w = (cur_width < 1) ? 1 : (cur_width > 8192 ? 8192 : cur_width);
        h = (cur_height < 1) ? 1 : (cur_height > 8192 ? 8192 : cur_height);
        if (half < 1)
            half = 1;
        py = longint'(row) - half;
        px = longint'(col) - half;
        ux = sat20(px * 65536 / half);
        uy = sat20(py * 65536 / half);
        if (py > px + half)
            rg = RGN_SIDE0;
        else if (py < px - half)
            rg = RGN_SIDE1;
        else if (py > -px + half)
            rg = RGN_SIDE2;
        else if (py < -px - half)
            rg = RGN_SIDE3;
        else
            rg = RGN_BASE;
        if (rg == RGN_BASE)
        begin
            v0 = ux;
            v1 = uy;
            v2 = -46341;
        end
        else
        begin
            d = (rg == RGN_SIDE0 || rg == RGN_SIDE1) ? py - px : py + px;
            b = sat20(d * 65536 / half);
            t = 65536 - (b < 0 ? -b : b);
            t = sat20(t < 0 ? -t : t);
            s = t - 65536;
            s = sat20(s < 0 ? -s : s);
            ax = (rg == RGN_SIDE0 || rg == RGN_SIDE3) ? ux + t : ux - t;
            ay = (rg == RGN_SIDE1 || rg == RGN_SIDE3) ? uy + t : uy - t;
            v0 = sat20((ax * s) >>> 16);
            v1 = sat20((ay * s) >>> 16);
            v2 = sat20(2 * t - 46341);
        end
        a1 = turn_angle(v0, v1, m);
        rho = (m * 64'sd652032874) >>> 30;
        a2 = turn_angle(rho, v2, dm);
        tt = a1 + TURN / 2;
        pp = a2 + TURN / 4;
        scol = ((2 * tt * w - TURN) >>> (ANGLE_BITS + 1)) + w / 2;
        if (scol > w)
            scol -= w;
        scol = scol < 0 ? 0 : (scol > w - 1 ? w - 1 : scol);
        srow = (4 * pp * h - TURN) >>> (ANGLE_BITS + 1);
        srow = srow < 0 ? 0 : (srow > h - 1 ? h - 1 : srow);
        r.src_row = 13'(srow);
        r.src_col = 13'(scol);
        r.region  = rg;
        return r;
    endfunction

    assign pending = coord_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        remap_t e;
        if (!rst_n)
        begin
            cur_size   <= 13'd1024;
            cur_width  <= 14'd4096;
            cur_height <= 14'd2048;
            fail_count <= 0;
            matched    <= 0;
            coord_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_OUT_SIZE:   cur_size   <= cfg_data[12:0];
                    CFG_SRC_WIDTH:  cur_width  <= cfg_data;
                    CFG_SRC_HEIGHT: cur_height <= cfg_data;
                    default: ;
                endcase
            end
            if (pix.valid && pix.ready)
                coord_q.push_back(remap_pixel(pix.out_row, pix.out_col));
            if (res.valid && res.ready)
            begin
                if (coord_q.size() == 0)
                begin
                    $display("%0t: unexpected item row %0d col %0d region %0d",
                             $time, res.src_row, res.src_col, res.region);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = coord_q.pop_front();
                    if (res.src_row !== e.src_row || res.src_col !== e.src_col ||
                        res.region !== e.region)
                    begin
                        $display("%0t: expected row %0d col %0d region %0d, got %0d %0d %0d",
                                 $time, e.src_row, e.src_col, e.region,
                                 res.src_row, res.src_col, res.region);
                        fail_count <= fail_count + 1;
                    end
                    else
                        matched <= matched + 1;
                end
            end
        end
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Top of the remap testbench: clock, reset, config phases, pixel stimulus,
// result back-pressure and verdict. Needs the block, its interfaces and e2p_remap_checker.
module tb
    import e2p_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [13:0] cfg_data;
    int          fail_count;
    int          pending;
    int          matched;
    int          sent;
    bit          hold_long;
    longint      cycles;

    e2p_pix_if pix ();
    e2p_res_if res ();

    equirect_to_pyramid_remap_unit u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .pix(pix), .res(res)
    );

    e2p_remap_checker u_chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .pix(pix), .res(res), .fail_count(fail_count),
        .pending(pending), .matched(matched)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: random stalls, one long hold-off on request
    initial
    begin
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_long)
            begin
                res.ready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_long = 1'b0;
            end
            else if (cycles % 2000 < 500)
                res.ready <= 1'b1;
            else
                res.ready <= (gap_len() == 0);
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [13:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_pixel(logic [11:0] row, logic [11:0] col, bit no_gap);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0)
        begin
            pix.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        pix.valid   <= 1'b1;
        pix.out_row <= row;
        pix.out_col <= col;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic drain();
        pix.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (90) @(negedge clk);
    endtask

    task automatic setup(logic [13:0] sz, logic [13:0] w, logic [13:0] h);
        write_reg(CFG_OUT_SIZE, sz);
        write_reg(CFG_SRC_WIDTH, w);
        write_reg(CFG_SRC_HEIGHT, h);
    endtask

    task automatic random_phase(int n, int sz);
        int lim;
        lim = (sz < 2) ? 2 : sz;
        for (int i = 0; i < n; i++)
        begin
            // mostly inside the image, some anywhere
            if ($urandom_range(0, 9) < 8)
                send_pixel(12'($urandom_range(0, lim - 1)), 12'($urandom_range(0, lim - 1)),
                           1'b0);
            else
                send_pixel(12'($urandom), 12'($urandom), 1'b0);
        end
        drain();
    endtask

    initial
    begin
        logic [11:0] edge_vals[6];
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_OUT_SIZE;
        cfg_data    = '0;
        pix.valid   = 1'b0;
        pix.out_row = '0;
        pix.out_col = '0;
        hold_long   = 1'b0;
        sent        = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, reset config: corners, centre, diagonals, beyond-image
        edge_vals = '{12'd0, 12'd256, 12'd511, 12'd512, 12'd1023, 12'hFFF};
        foreach (edge_vals[i])
            send_pixel(edge_vals[i], edge_vals[(i + 2) % 6], 1'b1);
        send_pixel(12'd512, 12'd512, 1'b1);
        send_pixel(12'd100, 12'd512, 1'b1);
        send_pixel(12'd900, 12'd512, 1'b1);
        send_pixel(12'd512, 12'd100, 1'b1);
        send_pixel(12'd512, 12'd900, 1'b1);
        send_pixel(12'd0, 12'd0, 1'b1);
        send_pixel(12'hFFF, 12'hFFF, 1'b1);
        send_pixel(12'hAAA, 12'h555, 1'b1);
        drain();

        // tiny and odd sizes, zero and oversize source dimensions
        setup(14'd1, 14'd0, 14'd0);
        send_pixel(12'd0, 12'd0, 1'b1);
        send_pixel(12'd1, 12'd0, 1'b1);
        send_pixel(12'd0, 12'd1, 1'b1);
        drain();
        setup(14'd2, 14'h3FFF, 14'd8192);
        send_pixel(12'd1, 12'd1, 1'b1);
        send_pixel(12'd0, 12'd2, 1'b1);
        drain();
        setup(14'd7, 14'd1, 14'd1);
        send_pixel(12'd3, 12'd6, 1'b1);
        drain();

        setup(14'd4096, 14'd8192, 14'd8192);
        random_phase(150, 4096);
        // long hold-off while pixels keep coming
        setup(14'd64, 14'd640, 14'd320);
        hold_long = 1'b1;
        random_phase(200, 64);
        setup(14'd1023, 14'd1000, 14'd777);
        random_phase(200, 1023);
        setup(14'd8191, 14'd3, 14'd9000);
        random_phase(100, 4096);
        setup(14'd2, 14'd1, 14'd1);
        random_phase(100, 2);
        setup(14'd300, 14'd4095, 14'd2047);
        random_phase(150, 300);

        $display("Sent %0d pixels over ten register settings, %0d results matched.",
                 sent, matched);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
